// ===== src/annexb_pkg.sv =====
// ----------------------------------------------------------------------------
// annexb_pkg
// shared types and constants for the annex b nal splitter and classifier
// ----------------------------------------------------------------------------
package annexb_pkg;

  localparam int MAX_NAL_BYTES = 1048576;
  // counter headroom above the largest length so saturation is visible
  localparam int TALLY_CAP     = MAX_NAL_BYTES + 64;
  localparam int TALLY_W       = $clog2(TALLY_CAP + 1);
  localparam int LEN_W         = 21;
  localparam int CNT_W         = 32;
  localparam int OUT_BITS      = 2 + 1 + 2 + 5 + 1 + LEN_W + 3 + CNT_W;
  localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;
  localparam int ZRUN_W        = 6;
  localparam logic [ZRUN_W-1:0] ZRUN_MAX = ZRUN_W'(32);

  localparam logic [3:0] KIND_BAD = 4'd15;

  typedef enum logic {
    PH_PREFIX  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  typedef enum logic [1:0] {
    GS_FIRST  = 2'd0,
    GS_SECOND = 2'd1,
    GS_DONE   = 2'd2,
    GS_BAD    = 2'd3
  } gstage_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_PREFIX = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FC_OTHER = 3'd0,
    FC_P     = 3'd1,
    FC_B     = 3'd2,
    FC_I     = 3'd3,
    FC_SEI   = 3'd4,
    FC_SPS   = 3'd5,
    FC_PPS   = 3'd6
  } fclass_t;

  localparam logic [4:0] NUT_SLICE = 5'd1;
  localparam logic [4:0] NUT_IDR   = 5'd5;
  localparam logic [4:0] NUT_SEI   = 5'd6;
  localparam logic [4:0] NUT_SPS   = 5'd7;
  localparam logic [4:0] NUT_PPS   = 5'd8;

  // slice header parse state as seen after the current byte
  typedef struct packed {
    gstage_t              stage;
    logic [3:0]           kind;
    logic [TALLY_W-1:0]   end_index;
  } gview_t;

  // one nal descriptor
  typedef struct packed {
    logic [CNT_W-1:0] i_slice_total;
    fclass_t          frame_class;
    logic [LEN_W-1:0] payload_length;
    logic             long_prefix;
    logic [4:0]       unit_type;
    logic [1:0]       ref_idc;
    logic             forbidden_flag;
    status_t          status;
  } nal_desc_t;

  // slice_type to frame class
  function automatic fclass_t slice_class(input logic [3:0] kind);
    fclass_t c;
    c = FC_OTHER;
    case (kind)
      4'd0, 4'd3, 4'd5, 4'd8: c = FC_P;
      4'd1, 4'd6:             c = FC_B;
      4'd2, 4'd4, 4'd7, 4'd9: c = FC_I;
      default:                c = FC_OTHER;
    endcase
    return c;
  endfunction

endpackage

// ===== src/annexb_golomb.sv =====
// ----------------------------------------------------------------------------
// annexb_golomb
// bytewise exp-golomb decoder for first_mb and slice_type of a slice header
// ----------------------------------------------------------------------------
module annexb_golomb
  import annexb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,        // consume one byte
  input  logic               clear,     // new nal opens
  input  logic [7:0]         data,
  input  logic [TALLY_W-1:0] index,
  output gview_t             view
);

  gstage_t             stage_r, stage_nxt;
  logic [ZRUN_W-1:0]   zrun_r, zrun_nxt;
  logic                nz_r, nz_nxt;     // leading one seen
  logic [3:0]          val_r, val_nxt;   // value, low bits
  logic                ovf_r, ovf_nxt;   // value grew past 15
  logic [3:0]          kind_r, kind_nxt;
  logic [TALLY_W-1:0]  end_r, end_nxt;

  always_comb begin
    logic done;
    stage_nxt = stage_r;
    zrun_nxt  = zrun_r;
    nz_nxt    = nz_r;
    val_nxt   = val_r;
    ovf_nxt   = ovf_r;
    kind_nxt  = kind_r;
    end_nxt   = end_r;
    done      = 1'b0;
    if (en) begin
      for (int i = 7; i >= 0; i--) begin
        if (stage_nxt == GS_FIRST || stage_nxt == GS_SECOND) begin
          done = 1'b0;
          if (!nz_nxt) begin
            if (!data[i]) begin
              zrun_nxt = zrun_nxt + 1'b1;
              if (zrun_nxt > ZRUN_MAX) begin
                stage_nxt = GS_BAD;
              end
            end else begin
              nz_nxt  = 1'b1;
              val_nxt = 4'd1;
              ovf_nxt = 1'b0;
              done    = (zrun_nxt == '0);
            end
          end else begin
            ovf_nxt  = ovf_nxt | val_nxt[3];
            val_nxt  = {val_nxt[2:0], data[i]};
            zrun_nxt = zrun_nxt - 1'b1;
            done     = (zrun_nxt == '0);
          end
          if (done) begin
            if (stage_nxt == GS_FIRST) begin
              stage_nxt = GS_SECOND;
            end else begin
              kind_nxt  = (!ovf_nxt && val_nxt <= 4'd10) ? (val_nxt - 4'd1) : KIND_BAD;
              stage_nxt = GS_DONE;
              end_nxt   = index;
            end
            zrun_nxt = '0;
            nz_nxt   = 1'b0;
            val_nxt  = '0;
            ovf_nxt  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      stage_r <= GS_FIRST;
      zrun_r  <= '0;
      nz_r    <= 1'b0;
      val_r   <= '0;
      ovf_r   <= 1'b0;
      kind_r  <= '0;
      end_r   <= '0;
    end else if (en) begin
      stage_r <= stage_nxt;
      zrun_r  <= zrun_nxt;
      nz_r    <= nz_nxt;
      val_r   <= val_nxt;
      ovf_r   <= ovf_nxt;
      kind_r  <= kind_nxt;
      end_r   <= end_nxt;
    end
  end

  assign view.stage     = stage_nxt;
  assign view.kind      = kind_nxt;
  assign view.end_index = end_nxt;

endmodule

// ===== src/annexb_core.sv =====
// ----------------------------------------------------------------------------
// annexb_core
// start code tracking, length count and descriptor build for one byte a cycle while step is high
// ----------------------------------------------------------------------------
module annexb_core
  import annexb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,       // process one byte
  input  logic [7:0] data,
  input  logic       eos,
  output logic       res_valid,
  output nal_desc_t  res
);

  phase_t              phase_r, phase_nxt;
  logic [23:0]         recent_r, recent_nxt;
  logic [2:0]          seen_r, seen_nxt;
  logic                long_r, long_nxt;
  logic [TALLY_W-1:0]  tally_r, tally_nxt;
  logic [7:0]          hdr_r, hdr_nxt;
  logic [CNT_W-1:0]    icnt_r, icnt_nxt;

  logic                g_en, g_clear;
  gview_t              gv;

  logic [23:0]         shifted;
  logic [2:0]          seen_inc;
  logic [TALLY_W-1:0]  tally_inc;
  logic                long_hit, short_hit, emit;
  logic                open_nal, open_long, to_prefix;
  logic [TALLY_W-1:0]  len;

  assign shifted   = {recent_r[15:0], data};
  assign seen_inc  = seen_r + 3'd1;
  assign tally_inc = (tally_r < TALLY_W'(TALLY_CAP)) ? tally_r + 1'b1 : tally_r;
  assign long_hit  = (recent_r == 24'h0) && (data == 8'h01);
  assign short_hit = !long_hit && (recent_r[15:0] == 16'h0) && (data == 8'h01);
  assign len       = long_hit  ? tally_inc - TALLY_W'(4) :
                     short_hit ? tally_inc - TALLY_W'(3) : tally_inc;

  assign g_en    = step && (phase_r == PH_PAYLOAD) && (tally_r != '0);
  assign g_clear = step && open_nal;

  annexb_golomb u_golomb (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (g_en),
    .clear (g_clear),
    .data  (data),
    .index (tally_r),
    .view  (gv)
  );

  // phase transitions
  always_comb begin
    phase_nxt = phase_r;
    open_nal  = 1'b0;
    open_long = 1'b0;
    to_prefix = 1'b0;
    unique case (phase_r)
      PH_PREFIX: begin
        if (seen_inc == 3'd3 && shifted == 24'h000001) begin
          open_nal  = !eos;
          to_prefix = eos;
        end else if (seen_inc >= 3'd4) begin
          open_nal  = !eos && long_hit;
          open_long = 1'b1;
          to_prefix = eos || !long_hit;
        end else begin
          to_prefix = eos;
        end
      end
      PH_PAYLOAD: begin
        if (long_hit || short_hit) begin
          open_nal  = !eos;
          open_long = long_hit;
          to_prefix = eos;
        end else begin
          to_prefix = eos;
        end
      end
      default: begin
        to_prefix = 1'b1;
      end
    endcase
    if (open_nal) begin
      phase_nxt = PH_PAYLOAD;
    end else if (to_prefix) begin
      phase_nxt = PH_PREFIX;
    end
  end

  // datapath and descriptor
  always_comb begin
    logic [7:0] hdr_eff;
    fclass_t    cls;
    recent_nxt = recent_r;
    seen_nxt   = seen_r;
    long_nxt   = long_r;
    tally_nxt  = tally_r;
    hdr_nxt    = hdr_r;
    icnt_nxt   = icnt_r;
    emit       = 1'b0;
    res        = '0;
    hdr_eff    = '0;
    cls        = FC_OTHER;

    if (phase_r == PH_PREFIX) begin
      recent_nxt = shifted;
      seen_nxt   = seen_inc;
      if (seen_inc >= 3'd4 && !long_hit) begin
        emit       = 1'b1;
        res.status = ST_NO_PREFIX;
      end
    end else begin
      if (tally_r == '0) begin
        hdr_nxt = data;
      end
      tally_nxt  = tally_inc;
      recent_nxt = shifted;
      emit       = long_hit || short_hit || eos;
      if (len != '0) begin
        hdr_eff = hdr_nxt;
      end
      if (len != '0 && (hdr_eff[4:0] == NUT_SLICE || hdr_eff[4:0] == NUT_IDR)) begin
        if (gv.stage == GS_DONE && gv.end_index < len) begin
          cls = slice_class(gv.kind);
          // the i slice count moves only when the descriptor goes out
          if (emit && (gv.kind == 4'd2 || gv.kind == 4'd7)) begin
            icnt_nxt = icnt_r + 1'b1;
          end
        end
      end else if (hdr_eff[4:0] == NUT_SEI) begin
        cls = FC_SEI;
      end else if (hdr_eff[4:0] == NUT_SPS) begin
        cls = FC_SPS;
      end else if (hdr_eff[4:0] == NUT_PPS) begin
        cls = FC_PPS;
      end
      res.status         = (len > TALLY_W'(MAX_NAL_BYTES)) ? ST_SATURATED : ST_OK;
      res.forbidden_flag = hdr_eff[7];
      res.ref_idc        = hdr_eff[6:5];
      res.unit_type      = hdr_eff[4:0];
      res.long_prefix    = long_r;
      res.payload_length = (len > TALLY_W'(MAX_NAL_BYTES)) ? LEN_W'(MAX_NAL_BYTES)
                                                          : LEN_W'(len);
      res.frame_class    = cls;
    end
    res.i_slice_total = icnt_nxt;

    if (open_nal) begin
      recent_nxt = 24'h000001;
      seen_nxt   = '0;
      long_nxt   = open_long;
      tally_nxt  = '0;
      hdr_nxt    = '0;
    end else if (to_prefix) begin
      recent_nxt = '0;
      seen_nxt   = '0;
    end
  end

  assign res_valid = step && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      recent_r <= '0;
      seen_r   <= '0;
      long_r   <= 1'b0;
      tally_r  <= '0;
      hdr_r    <= '0;
      icnt_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      recent_r <= recent_nxt;
      seen_r   <= seen_nxt;
      long_r   <= long_nxt;
      tally_r  <= tally_nxt;
      hdr_r    <= hdr_nxt;
      icnt_r   <= icnt_nxt;
    end
  end

endmodule

// ===== src/annexb_nal_splitter_classifier.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_splitter_classifier
// splits an annex b byte stream at start codes and reports one descriptor per nal
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                   framing
//   -------  ---  ----------------------------------------  ----------------------
//   in_*     in   tdata = data_byte                         tlast = end_of_stream
//   out_*    out  tdata = nal descriptor (see port comment)  none
//
// one byte per clock sustained while the output is taken: each transfer enters
// the input register, is processed by the start code, length and slice header
// logic and lands in the output register, so out_tvalid rises once the byte that
// ends its nal has gone through the input register and the output register.
// a byte that ends nothing gives no output transfer.
// rst_n is synchronous; it clears both valid bits, the phase and i slice count.
// while the output register holds an untaken descriptor the input register
// holds too, whether or not its byte ends a nal, and in_tready drops only if it
// is also full.
//
module annexb_nal_splitter_classifier
  import annexb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tlast,   // end_of_stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [1:0] status, [2] forbidden_flag,
                                       // [4:3] ref_idc, [9:5] unit_type,
                                       // [10] long_prefix, [31:11] payload_length,
                                       // [34:32] frame_class, [66:35] i_slice_total,
                                       // upper bits zero
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eos_r;
  logic       out_valid_r;
  nal_desc_t  out_desc_r;

  logic       out_free;
  logic       advance;
  logic       res_valid;
  nal_desc_t  res;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_eos_r  <= in_tlast;
    end
  end

  annexb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data      (s1_byte_r),
    .eos       (s1_eos_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_desc_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, out_desc_r};

endmodule
